// File: rtl/delayed_time_window_sum_core_defines.svh
// assertion helpers for the delayed time-window sum core
`ifndef DELAYED_TIME_WINDOW_SUM_CORE_DEFINES_SVH
`define DELAYED_TIME_WINDOW_SUM_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DTWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dtws check failed");

// next-cycle implication, checked outside reset
`define DTWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dtws check failed");

`endif

// File: rtl/dtws_pkg.sv
`default_nettype none

package dtws_pkg;

	localparam int RING_DEPTH = 1024;

	localparam int TIME_W  = 32;
	localparam int VALUE_W = 32;
	localparam int SUM_W   = 48;
	localparam int COUNT_W = 11;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 1;

	// signed window bounds: time minus age needs one extra bit plus sign
	localparam int BOUND_W = TIME_W + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_AGE = 1'b0,
		CFG_END_AGE   = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TIME_BAD = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EV_RD,
		S_EV_CHK,
		S_CT_RD,
		S_CT_CHK,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// File: rtl/dtws_sample_if.sv
`default_nettype none

interface dtws_sample_if;
	logic                                     valid;
	logic                                     ready;
	logic        [dtws_pkg::TIME_W-1:0]       sample_time;
	logic signed [dtws_pkg::VALUE_W-1:0]      sample_value;

	modport source (output valid, output sample_time, output sample_value, input ready);
	modport sink   (input valid, input sample_time, input sample_value, output ready);
endinterface

`default_nettype wire

// File: rtl/dtws_result_if.sv
`default_nettype none

interface dtws_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [dtws_pkg::SUM_W-1:0]   window_sum;
	logic        [dtws_pkg::COUNT_W-1:0] window_count;
	logic        [1:0]                   status;

	modport source (output valid, output window_sum, output window_count, output status,
		input ready);
	modport sink   (input valid, input window_sum, input window_count, input status,
		output ready);
endinterface

`default_nettype wire

// File: rtl/dtws_cfg_if.sv
`default_nettype none

interface dtws_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [dtws_pkg::CFG_IDX_W-1:0]    index;
	logic [dtws_pkg::CFG_W-1:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/delayed_time_window_sum_core.sv
`default_nettype none
`include "delayed_time_window_sum_core_defines.svh"

// Delayed time-window sum. Each accepted sample word (time, Q16.16 value)
// is appended to a ring of RING_DEPTH entries; with t the new time the
// window runs from t - window_start_age to t - window_end_age. Entries
// older than the window start are evicted (and taken out of the sum if they
// had been counted), then stored entries at or below the window end are
// counted in time order. Every sample word yields exactly one result word
// holding the 48-bit sum, the count and a status (accepted, time not
// increasing, ring full); a rejected sample leaves all state untouched.
// One sample is worked on at a time; a rejected sample goes straight to
// its result, while an accepted one is paced by the ring's single read
// port: every evicted or counted entry is one registered read followed by
// one pass through the shared compare and 48-bit add/subtract unit. A
// result word waiting at the output does not stop the next sample word
// from being taken; only the final load of the result register waits for
// it. Configuration writes are always taken and are to be kept to idle
// periods by the user; the block itself leaves this unchecked. The ring
// needs no clearing after reset.
module delayed_time_window_sum_core #(
	parameter int RING_DEPTH = dtws_pkg::RING_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	dtws_sample_if.sink   sample,
	dtws_result_if.source result,
	dtws_cfg_if.sink      cfg
);

	localparam int AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W = AW + 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);
	localparam logic [AW-1:0]    LAST_C  = AW'(RING_DEPTH - 1);

	// ring storage, undefined until written
	logic [dtws_pkg::TIME_W-1:0]  time_mem  [RING_DEPTH];
	logic [dtws_pkg::VALUE_W-1:0] value_mem [RING_DEPTH];

	// control state
	dtws_pkg::state_t state_q, state_nxt;
	logic [AW-1:0]    oldest_q;    // slot of oldest stored sample
	logic [CNT_W-1:0] stored_q;    // samples in the ring
	logic [CNT_W-1:0] counted_q;   // oldest counted_q samples are in the sum
	logic signed [dtws_pkg::SUM_W-1:0] total_q;
	logic [dtws_pkg::TIME_W-1:0] newest_q;  // time of newest stored sample

	// configuration
	logic [dtws_pkg::TIME_W-1:0] start_age_q;
	logic [dtws_pkg::TIME_W-1:0] end_age_q;

	// per-sample work registers
	logic signed [dtws_pkg::BOUND_W-1:0] lo_q;
	logic signed [dtws_pkg::BOUND_W-1:0] hi_q;
	dtws_pkg::status_t status_q;
	logic [dtws_pkg::TIME_W-1:0]  rd_time_q;
	logic [dtws_pkg::VALUE_W-1:0] rd_value_q;

	// result register
	logic                                  out_valid_q;
	logic signed [dtws_pkg::SUM_W-1:0]     out_sum_q;
	logic        [dtws_pkg::COUNT_W-1:0]   out_count_q;
	dtws_pkg::status_t                     out_status_q;

	// handshakes
	logic in_acc;
	logic load_out;
	logic cfg_acc;

	// admission checks
	logic time_bad;
	logic ring_full;
	logic reject;

	// ring addressing
	logic [CNT_W-1:0] wr_sum;
	logic [AW-1:0]    wr_slot;
	logic [CNT_W-1:0] ct_sum;
	logic [AW-1:0]    ct_slot;
	logic [AW-1:0]    oldest_inc;
	logic [AW-1:0]    rd_addr;

	// shared compare and add/subtract unit
	logic signed [dtws_pkg::BOUND_W-1:0] bound;
	logic signed [dtws_pkg::BOUND_W-1:0] diff;
	logic older;
	logic past_end;
	logic signed [dtws_pkg::SUM_W-1:0] addend;
	logic signed [dtws_pkg::SUM_W-1:0] total_nxt;
	logic do_sub;

	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign in_acc    = sample.valid && sample.ready;

	// a sample must be newer than the newest stored one, and needs a free slot
	assign time_bad  = (stored_q != '0) && (sample.sample_time <= newest_q);
	assign ring_full = (stored_q == DEPTH_C);
	assign reject    = time_bad || ring_full;

	// slot arithmetic stays below twice the depth: one compare and subtract
	assign wr_sum  = CNT_W'(oldest_q) + stored_q;
	assign wr_slot = (wr_sum >= DEPTH_C) ? AW'(wr_sum - DEPTH_C) : AW'(wr_sum);
	assign ct_sum  = CNT_W'(oldest_q) + counted_q;
	assign ct_slot = (ct_sum >= DEPTH_C) ? AW'(ct_sum - DEPTH_C) : AW'(ct_sum);
	assign oldest_inc = (oldest_q == LAST_C) ? '0 : oldest_q + AW'(1);

	// one signed subtract serves both window edges
	assign bound    = (state_q == dtws_pkg::S_EV_CHK) ? lo_q : hi_q;
	assign diff     = $signed({2'b00, rd_time_q}) - bound;
	assign older    = diff[dtws_pkg::BOUND_W-1];
	assign past_end = !diff[dtws_pkg::BOUND_W-1] && (diff != '0);

	// one 48-bit adder: subtract on eviction, add on counting
	assign addend    = dtws_pkg::SUM_W'($signed(rd_value_q));
	assign do_sub    = (state_q == dtws_pkg::S_EV_CHK);
	assign total_nxt = do_sub ? (total_q - addend) : (total_q + addend);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dtws_pkg::S_IDLE: begin
				if (in_acc) begin
					state_nxt = reject ? dtws_pkg::S_DONE : dtws_pkg::S_EV_RD;
				end
			end
			dtws_pkg::S_EV_RD: begin
				state_nxt = dtws_pkg::S_EV_CHK;
			end
			dtws_pkg::S_EV_CHK: begin
				state_nxt = (older && stored_q != '0) ? dtws_pkg::S_EV_RD
					: dtws_pkg::S_CT_RD;
			end
			dtws_pkg::S_CT_RD: begin
				state_nxt = (counted_q < stored_q) ? dtws_pkg::S_CT_CHK
					: dtws_pkg::S_DONE;
			end
			dtws_pkg::S_CT_CHK: begin
				state_nxt = past_end ? dtws_pkg::S_DONE : dtws_pkg::S_CT_RD;
			end
			dtws_pkg::S_DONE: begin
				if (load_out) begin
					state_nxt = dtws_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = dtws_pkg::S_IDLE;
			end
		endcase
	end

	// state-driven controls
	always_comb begin
		sample.ready = 1'b0;
		load_out     = 1'b0;
		rd_addr      = oldest_q;
		unique case (state_q)
			dtws_pkg::S_IDLE: begin
				sample.ready = 1'b1;
			end
			dtws_pkg::S_CT_RD: begin
				rd_addr = ct_slot;
			end
			dtws_pkg::S_DONE: begin
				load_out = !out_valid_q || result.ready;
			end
			default: begin
				rd_addr = oldest_q;
			end
		endcase
	end

	// ring memories: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (in_acc && !reject) begin
			time_mem[wr_slot]  <= sample.sample_time;
			value_mem[wr_slot] <= sample.sample_value;
		end
		rd_time_q  <= time_mem[rd_addr];
		rd_value_q <= value_mem[rd_addr];
	end

	// window bounds and status of the sample at hand
	always_ff @(posedge clk) begin
		if (in_acc) begin
			lo_q <= $signed({2'b00, sample.sample_time}) - $signed({2'b00, start_age_q});
			hi_q <= $signed({2'b00, sample.sample_time}) - $signed({2'b00, end_age_q});
			if (time_bad) begin
				status_q <= dtws_pkg::ST_TIME_BAD;
			end else if (ring_full) begin
				status_q <= dtws_pkg::ST_FULL;
			end else begin
				status_q <= dtws_pkg::ST_OK;
			end
		end
	end

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dtws_pkg::S_IDLE;
			oldest_q  <= '0;
			stored_q  <= '0;
			counted_q <= '0;
			total_q   <= '0;
			newest_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_acc && !reject) begin
				stored_q <= stored_q + CNT_W'(1);
				newest_q <= sample.sample_time;
			end
			if (state_q == dtws_pkg::S_EV_CHK && older && stored_q != '0) begin
				if (counted_q != '0) begin
					total_q   <= total_nxt;
					counted_q <= counted_q - CNT_W'(1);
				end
				oldest_q <= oldest_inc;
				stored_q <= stored_q - CNT_W'(1);
			end
			if (state_q == dtws_pkg::S_CT_CHK && !past_end) begin
				total_q   <= total_nxt;
				counted_q <= counted_q + CNT_W'(1);
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_age_q <= '0;
			end_age_q   <= '0;
		end else if (cfg_acc) begin
			unique case (dtws_pkg::cfg_idx_t'(cfg.index))
				dtws_pkg::CFG_START_AGE: start_age_q <= cfg.data;
				dtws_pkg::CFG_END_AGE:   end_age_q   <= cfg.data;
				default: begin
					start_age_q <= start_age_q;
				end
			endcase
		end
	end

	// result register, parts the sequencer from the result consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_sum_q    <= total_q;
			out_count_q  <= dtws_pkg::COUNT_W'(counted_q);
			out_status_q <= status_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.window_sum   = out_sum_q;
	assign result.window_count = out_count_q;
	assign result.status       = out_status_q;

	`DTWS_ASSERT_NOW(a_counted_le_stored, clk, arst_n, 1'b1, counted_q <= stored_q)
	`DTWS_ASSERT_NOW(a_stored_le_depth, clk, arst_n, 1'b1, stored_q <= DEPTH_C)
	`DTWS_ASSERT_NEXT(a_reject_keeps_ring, clk, arst_n, in_acc && reject,
		stored_q == $past(stored_q) && state_q == dtws_pkg::S_DONE)
	`DTWS_ASSERT_NEXT(a_accept_grows_ring, clk, arst_n, in_acc && !reject,
		stored_q == $past(stored_q) + CNT_W'(1) && state_q == dtws_pkg::S_EV_RD)

endmodule

`default_nettype wire
